FILE: hw/rtl/aarm_pkg.sv
// Shared constants for the axis-angle rotation matrix pipeline.
// No dependencies.
package aarm_pkg;

    localparam int unsigned IN_W    = 16;
    localparam int unsigned OUT_W   = 16;
    localparam int unsigned SQ_W    = 32;
    localparam int          OUT_MAX = 32767;
    localparam int          OUT_MIN = -32768;

endpackage

FILE: hw/rtl/axis_angle_rotation_matrix.sv
// Axis-angle (Rodrigues) rotation matrix pipeline.
// Depends on aarm_pkg.
//
// Usage:
//   Input channel i_valid/o_ready carries sine, cosine (signed Q(FRAC_BITS))
//   and an unnormalized axis (x, y, z, any common scale). Output channel
//   o_valid/i_ready carries the nine matrix entries, saturated to 16 bits,
//   and o_axis_zero, set when the axis is the zero vector (identity out).
//   Registers in order: input squares, squared norm, a register per result
//   bit of the exact inverse-square-root search (shift-and-add, no
//   multiplier), then P1 to P4 for the two rounds of products and rounding,
//   and the output register with the sums and saturation.
//   Throughput: one transfer per cycle, set by the fully pipelined datapath,
//   while the receiver does not stall. The output stage is a register; when
//   the receiver stalls the whole pipeline holds, so o_ready drops only while
//   the output register is full and not taken. Nothing is dropped or repeated.
//   Reset clears all valid bits; the pipeline is empty after reset.
module axis_angle_rotation_matrix #(
    parameter int FRAC_BITS = 14
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [aarm_pkg::IN_W-1:0]  i_sine_value,
    input  logic signed [aarm_pkg::IN_W-1:0]  i_cosine_value,
    input  logic signed [aarm_pkg::IN_W-1:0]  i_axis_x,
    input  logic signed [aarm_pkg::IN_W-1:0]  i_axis_y,
    input  logic signed [aarm_pkg::IN_W-1:0]  i_axis_z,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [aarm_pkg::OUT_W-1:0] o_rot_r0c0,
    output logic signed [aarm_pkg::OUT_W-1:0] o_rot_r0c1,
    output logic signed [aarm_pkg::OUT_W-1:0] o_rot_r0c2,
    output logic signed [aarm_pkg::OUT_W-1:0] o_rot_r1c0,
    output logic signed [aarm_pkg::OUT_W-1:0] o_rot_r1c1,
    output logic signed [aarm_pkg::OUT_W-1:0] o_rot_r1c2,
    output logic signed [aarm_pkg::OUT_W-1:0] o_rot_r2c0,
    output logic signed [aarm_pkg::OUT_W-1:0] o_rot_r2c1,
    output logic signed [aarm_pkg::OUT_W-1:0] o_rot_r2c2,
    output logic                              o_axis_zero
);
    import aarm_pkg::*;

    localparam int F   = FRAC_BITS;
    localparam int QW  = ((F > 15) ? F : 15) + 3;  // signed Q value width
    localparam int PPW = 2 * QW;                   // raw product width
    localparam int SW  = 2 * F + 38;               // root search accumulators
    localparam int UW  = F + 3;                    // u = 2q
    localparam logic signed [QW-1:0] ONE  = {{(QW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
    localparam logic signed [QW:0]   SMAX = (QW+1)'(OUT_MAX);
    localparam logic signed [QW:0]   SMIN = (QW+1)'(OUT_MIN);

    typedef struct packed {
        logic                     v;
        logic signed [IN_W-1:0]   s;
        logic signed [IN_W-1:0]   c;
        logic                     zero;
        logic [SQ_W-1:0]          n2;
        logic [2:0]               neg;
        logic [2:0][SW-1:0]       rhs;
        logic [2:0][SW-1:0]       acc_a;   // u^2 * n2
        logic [2:0][SW-1:0]       acc_b;   // u * n2
        logic [2:0][UW-1:0]       u;
    } t_rt;

    function automatic logic signed [QW-1:0] f_qround(input logic signed [PPW-1:0] p);
        logic [PPW-1:0] m;
        logic [PPW-1:0] r;
        m = p[PPW-1] ? PPW'(-p) : PPW'(p);
        r = (m + (PPW'(1) << (F - 1))) >> F;
        return p[PPW-1] ? -QW'(r) : QW'(r);
    endfunction

    function automatic logic signed [OUT_W-1:0] f_sat(input logic signed [QW:0] v);
        if (v > SMAX) return OUT_W'(SMAX);
        if (v < SMIN) return OUT_W'(SMIN);
        return OUT_W'(v);
    endfunction

    logic en;
    logic r_ov;
    assign en      = !r_ov || i_ready;
    assign o_ready = en;
    assign o_valid = r_ov;

    // stage 1: magnitudes and squares
    logic                   r_v1;
    logic signed [IN_W-1:0] r_s1, r_c1;
    logic [2:0]             r_neg1;
    logic [2:0][SQ_W-1:0]   r_sq1;
    logic [2:0][IN_W-1:0]   mag;

    always_comb begin
        mag[0] = i_axis_x[IN_W-1] ? IN_W'(-i_axis_x) : IN_W'(i_axis_x);
        mag[1] = i_axis_y[IN_W-1] ? IN_W'(-i_axis_y) : IN_W'(i_axis_y);
        mag[2] = i_axis_z[IN_W-1] ? IN_W'(-i_axis_z) : IN_W'(i_axis_z);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
        end
        if (en) begin
            r_s1   <= i_sine_value;
            r_c1   <= i_cosine_value;
            r_neg1 <= {i_axis_z[IN_W-1], i_axis_y[IN_W-1], i_axis_x[IN_W-1]};
            for (int j = 0; j < 3; j++) begin
                r_sq1[j] <= SQ_W'(mag[j]) * SQ_W'(mag[j]);
            end
        end
    end

    // stage 2: norm, search targets; then one stage per result bit
    t_rt r_rt [0:F+1];
    t_rt n_rt0;

    always_comb begin
        n_rt0      = '0;
        n_rt0.v    = r_v1;
        n_rt0.s    = r_s1;
        n_rt0.c    = r_c1;
        n_rt0.neg  = r_neg1;
        n_rt0.n2   = r_sq1[0] + r_sq1[1] + r_sq1[2];
        n_rt0.zero = (n_rt0.n2 == '0);
        for (int j = 0; j < 3; j++) begin
            n_rt0.rhs[j] = SW'(r_sq1[j]) << (2 * F + 2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rt[0].v <= 1'b0;
        end else if (en) begin
            r_rt[0] <= n_rt0;
        end
    end

    for (genvar k = 0; k <= F; k++) begin : g_root
        localparam int BB = F - k;
        t_rt             n_rt;
        logic [SW-1:0]   n2w;
        logic [2:0][SW-1:0] trial;

        // test q | 2^BB: (2c-1)^2 * n2 <= 4 * mag^2 * 2^(2F)
        always_comb begin
            n_rt = r_rt[k];
            n2w  = SW'(r_rt[k].n2);
            for (int j = 0; j < 3; j++) begin
                trial[j] = r_rt[k].acc_a[j] + (r_rt[k].acc_b[j] << (BB + 2))
                         - (r_rt[k].acc_b[j] << 1) + (n2w << (2 * BB + 2))
                         - (n2w << (BB + 2)) + n2w;
                if (trial[j] <= r_rt[k].rhs[j]) begin
                    n_rt.u[j]     = r_rt[k].u[j] + (UW'(1) << (BB + 1));
                    n_rt.acc_a[j] = r_rt[k].acc_a[j] + (r_rt[k].acc_b[j] << (BB + 2))
                                  + (n2w << (2 * BB + 2));
                    n_rt.acc_b[j] = r_rt[k].acc_b[j] + (n2w << (BB + 1));
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rt[k+1].v <= 1'b0;
            end else if (en) begin
                r_rt[k+1] <= n_rt;
            end
        end
    end

    // P1: signed unit components, first products
    logic [2:0][QW-1:0] unit;
    t_rt rq;
    assign rq = r_rt[F+1];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            unit[j] = rq.neg[j] ? -QW'(rq.u[j][UW-1:1]) : QW'(rq.u[j][UW-1:1]);
        end
    end

    logic                    r_p1v, r_p1z;
    logic signed [QW-1:0]    r_p1omc, r_p1c;
    logic signed [PPW-1:0]   r_p1xx, r_p1yy, r_p1zz, r_p1xy, r_p1xz, r_p1yz;
    logic signed [PPW-1:0]   r_p1xs, r_p1ys, r_p1zs;
    logic signed [PPW-1:0]   ux, uy, uz, sw;

    assign ux = PPW'(signed'(unit[0]));
    assign uy = PPW'(signed'(unit[1]));
    assign uz = PPW'(signed'(unit[2]));
    assign sw = PPW'(rq.s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1v <= 1'b0;
        end else if (en) begin
            r_p1v <= rq.v;
        end
        if (en) begin
            r_p1z   <= rq.zero;
            r_p1c   <= QW'(rq.c);
            r_p1omc <= ONE - QW'(rq.c);
            r_p1xx  <= ux * ux;
            r_p1yy  <= uy * uy;
            r_p1zz  <= uz * uz;
            r_p1xy  <= ux * uy;
            r_p1xz  <= ux * uz;
            r_p1yz  <= uy * uz;
            r_p1xs  <= ux * sw;
            r_p1ys  <= uy * sw;
            r_p1zs  <= uz * sw;
        end
    end

    // P2: round first products
    logic                 r_p2v, r_p2z;
    logic signed [QW-1:0] r_p2omc, r_p2c, r_p2xx, r_p2yy, r_p2zz;
    logic signed [QW-1:0] r_p2xy, r_p2xz, r_p2yz, r_p2xs, r_p2ys, r_p2zs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2v <= 1'b0;
        end else if (en) begin
            r_p2v <= r_p1v;
        end
        if (en) begin
            r_p2z   <= r_p1z;
            r_p2omc <= r_p1omc;
            r_p2c   <= r_p1c;
            r_p2xx  <= f_qround(r_p1xx);
            r_p2yy  <= f_qround(r_p1yy);
            r_p2zz  <= f_qround(r_p1zz);
            r_p2xy  <= f_qround(r_p1xy);
            r_p2xz  <= f_qround(r_p1xz);
            r_p2yz  <= f_qround(r_p1yz);
            r_p2xs  <= f_qround(r_p1xs);
            r_p2ys  <= f_qround(r_p1ys);
            r_p2zs  <= f_qround(r_p1zs);
        end
    end

    // P3: second products
    logic                  r_p3v, r_p3z;
    logic signed [QW-1:0]  r_p3xx, r_p3yy, r_p3zz, r_p3xs, r_p3ys, r_p3zs;
    logic signed [PPW-1:0] r_p3dx, r_p3dy, r_p3dz, r_p3xy, r_p3xz, r_p3yz;
    logic signed [PPW-1:0] cw, omcw;

    assign cw   = PPW'(r_p2c);
    assign omcw = PPW'(r_p2omc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3v <= 1'b0;
        end else if (en) begin
            r_p3v <= r_p2v;
        end
        if (en) begin
            r_p3z  <= r_p2z;
            r_p3xx <= r_p2xx;
            r_p3yy <= r_p2yy;
            r_p3zz <= r_p2zz;
            r_p3xs <= r_p2xs;
            r_p3ys <= r_p2ys;
            r_p3zs <= r_p2zs;
            r_p3dx <= PPW'(ONE - r_p2xx) * cw;
            r_p3dy <= PPW'(ONE - r_p2yy) * cw;
            r_p3dz <= PPW'(ONE - r_p2zz) * cw;
            r_p3xy <= PPW'(r_p2xy) * omcw;
            r_p3xz <= PPW'(r_p2xz) * omcw;
            r_p3yz <= PPW'(r_p2yz) * omcw;
        end
    end

    // P4: round second products
    logic                 r_p4v, r_p4z;
    logic signed [QW-1:0] r_p4xx, r_p4yy, r_p4zz, r_p4xs, r_p4ys, r_p4zs;
    logic signed [QW-1:0] r_p4dx, r_p4dy, r_p4dz, r_p4xy, r_p4xz, r_p4yz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p4v <= 1'b0;
        end else if (en) begin
            r_p4v <= r_p3v;
        end
        if (en) begin
            r_p4z  <= r_p3z;
            r_p4xx <= r_p3xx;
            r_p4yy <= r_p3yy;
            r_p4zz <= r_p3zz;
            r_p4xs <= r_p3xs;
            r_p4ys <= r_p3ys;
            r_p4zs <= r_p3zs;
            r_p4dx <= f_qround(r_p3dx);
            r_p4dy <= f_qround(r_p3dy);
            r_p4dz <= f_qround(r_p3dz);
            r_p4xy <= f_qround(r_p3xy);
            r_p4xz <= f_qround(r_p3xz);
            r_p4yz <= f_qround(r_p3yz);
        end
    end

    // output register: sums, saturation, zero-axis identity
    logic signed [OUT_W-1:0] diag_one;
    assign diag_one = f_sat((QW+1)'(ONE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_p4v;
        end
        if (en) begin
            o_axis_zero <= r_p4z;
            if (r_p4z) begin
                o_rot_r0c0 <= diag_one;
                o_rot_r0c1 <= '0;
                o_rot_r0c2 <= '0;
                o_rot_r1c0 <= '0;
                o_rot_r1c1 <= diag_one;
                o_rot_r1c2 <= '0;
                o_rot_r2c0 <= '0;
                o_rot_r2c1 <= '0;
                o_rot_r2c2 <= diag_one;
            end else begin
                o_rot_r0c0 <= f_sat((QW+1)'(r_p4xx) + (QW+1)'(r_p4dx));
                o_rot_r0c1 <= f_sat((QW+1)'(r_p4xy) - (QW+1)'(r_p4zs));
                o_rot_r0c2 <= f_sat((QW+1)'(r_p4xz) + (QW+1)'(r_p4ys));
                o_rot_r1c0 <= f_sat((QW+1)'(r_p4xy) + (QW+1)'(r_p4zs));
                o_rot_r1c1 <= f_sat((QW+1)'(r_p4yy) + (QW+1)'(r_p4dy));
                o_rot_r1c2 <= f_sat((QW+1)'(r_p4yz) - (QW+1)'(r_p4xs));
                o_rot_r2c0 <= f_sat((QW+1)'(r_p4xz) - (QW+1)'(r_p4ys));
                o_rot_r2c1 <= f_sat((QW+1)'(r_p4yz) + (QW+1)'(r_p4xs));
                o_rot_r2c2 <= f_sat((QW+1)'(r_p4zz) + (QW+1)'(r_p4dz));
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_zero_identity : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_axis_zero |-> o_rot_r0c1 == '0 && o_rot_r1c2 == '0 &&
        o_rot_r2c0 == '0 && o_rot_r1c1 == o_rot_r0c0)
        else $error("zero axis did not give identity");

    a_ready_rule : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("input ready does not follow output stall");

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");
`endif

endmodule

FILE: bench/rotation_checker.sv
// Checker for the axis-angle rotation matrix block: predicts each matrix from the
// input transfers and compares the output transfers in order. Depends on aarm_pkg.
`timescale 1ns / 1ps
module rotation_checker #(
    parameter int FRAC_BITS = 14
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic signed [aarm_pkg::IN_W-1:0]  i_sine,
    input  logic signed [aarm_pkg::IN_W-1:0]  i_cosine,
    input  logic signed [aarm_pkg::IN_W-1:0]  i_ax,
    input  logic signed [aarm_pkg::IN_W-1:0]  i_ay,
    input  logic signed [aarm_pkg::IN_W-1:0]  i_az,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic [8:0][aarm_pkg::OUT_W-1:0]   i_entries,
    input  logic                              i_axis_zero,
    output int                                o_mismatches,
    output int                                o_pending,
    output int                                o_matrices,
    output int                                o_zero_axes
);
    typedef struct packed {
        logic [8:0][aarm_pkg::OUT_W-1:0] ent;
        logic                            zero;
    } t_rot_matrix;

    t_rot_matrix matrix_q[$];

    function automatic longint round_mul(longint a, longint b);
        longint p;
        longint m;
        p = a * b;
        m = (p < 0) ? -p : p;
        m = (m + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        return (p < 0) ? -m : m;
    endfunction

    // exact round(|v| * 2^F / sqrt(n2)) by bitwise search on squared terms
    function automatic longint unit_axis(longint v, longint n2);
        logic [127:0] rhs;
        logic [127:0] lhs;
        longint mag;
        longint q;
        longint cand;
        longint t;
        mag = (v < 0) ? -v : v;
        rhs = 128'(4 * mag * mag) << (2 * FRAC_BITS);
        q = 0;
        for (int b = FRAC_BITS; b >= 0; b--) begin
            cand = q | (longint'(1) <<< b);
            t = 2 * cand - 1;
            lhs = 128'(t * t) * 128'(n2);
            if (lhs <= rhs)
                q = cand;
        end
        return (v < 0) ? -q : q;
    endfunction

    function automatic logic [aarm_pkg::OUT_W-1:0] clamp16(longint v);
        if (v > aarm_pkg::OUT_MAX) v = aarm_pkg::OUT_MAX;
        if (v < aarm_pkg::OUT_MIN) v = aarm_pkg::OUT_MIN;
        return v[aarm_pkg::OUT_W-1:0];
    endfunction

    function automatic t_rot_matrix predict_rotation(longint s, longint c, longint vx,
                                                     longint vy, longint vz);
        t_rot_matrix r;
        longint one, n2, x, y, z, omc, xx, yy, zz, xy, xz, yz, xs, ys, zs;
        longint m[9];
        one = longint'(1) <<< FRAC_BITS;
        n2 = vx * vx + vy * vy + vz * vz;
        if (n2 == 0) begin
            for (int i = 0; i < 9; i++)
                r.ent[i] = clamp16((i % 4 == 0) ? one : 0);
            r.zero = 1'b1;
            return r;
        end
        x = unit_axis(vx, n2);
        y = unit_axis(vy, n2);
        z = unit_axis(vz, n2);
        omc = one - c;
        xx = round_mul(x, x);
        yy = round_mul(y, y);
        zz = round_mul(z, z);
        xy = round_mul(round_mul(x, y), omc);
        xz = round_mul(round_mul(x, z), omc);
        yz = round_mul(round_mul(y, z), omc);
        xs = round_mul(x, s);
        ys = round_mul(y, s);
        zs = round_mul(z, s);
        m[0] = xx + round_mul(one - xx, c);
        m[1] = xy - zs;
        m[2] = xz + ys;
        m[3] = xy + zs;
        m[4] = yy + round_mul(one - yy, c);
        m[5] = yz - xs;
        m[6] = xz - ys;
        m[7] = yz + xs;
        m[8] = zz + round_mul(one - zz, c);
        for (int i = 0; i < 9; i++)
            r.ent[i] = clamp16(m[i]);
        r.zero = 1'b0;
        return r;
    endfunction

    initial begin
        o_mismatches = 0;
        o_matrices = 0;
        o_zero_axes = 0;
    end

    assign o_pending = matrix_q.size();

    always @(posedge i_clk) begin
        t_rot_matrix want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready)
                matrix_q.push_back(predict_rotation(i_sine, i_cosine, i_ax, i_ay, i_az));
            if (i_out_valid && i_out_ready) begin
                o_matrices++;
                if (i_axis_zero)
                    o_zero_axes++;
                if (matrix_q.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= 10)
                        $display("[%0t] unexpected output transfer", $time);
                end else begin
                    want = matrix_q.pop_front();
                    if (want.ent !== i_entries || want.zero !== i_axis_zero) begin
                        o_mismatches++;
                        if (o_mismatches <= 10)
                            $display("[%0t] matrix mismatch: want %h zero %b, got %h zero %b",
                                     $time, want.ent, want.zero, i_entries, i_axis_zero);
                    end
                end
            end
        end
    end
endmodule

FILE: bench/testbench.sv
// Top of the rotation matrix bench: clock, reset, bursty stimulus and a stalling
// receiver. Depends on aarm_pkg, axis_angle_rotation_matrix and rotation_checker.
`timescale 1ns / 1ps
module testbench;
    localparam int FRAC_BITS = 14;
    localparam int LATENCY = FRAC_BITS + 8;
    localparam int RANDOM_ITEMS = 1600;
    localparam int CYCLE_LIMIT = 600000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    logic o_ready, o_valid, o_axis_zero;
    logic signed [15:0] sine = '0, cosine = '0, ax = '0, ay = '0, az = '0;
    logic [8:0][15:0] entries;
    int mismatches, pending, matrices, zero_axes;
    int cycles = 0;
    bit stim_done = 1'b0;

    always #4 i_clk = ~i_clk;

    axis_angle_rotation_matrix #(.FRAC_BITS(FRAC_BITS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_sine_value(sine), .i_cosine_value(cosine),
        .i_axis_x(ax), .i_axis_y(ay), .i_axis_z(az),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_rot_r0c0(entries[0]), .o_rot_r0c1(entries[1]), .o_rot_r0c2(entries[2]),
        .o_rot_r1c0(entries[3]), .o_rot_r1c1(entries[4]), .o_rot_r1c2(entries[5]),
        .o_rot_r2c0(entries[6]), .o_rot_r2c1(entries[7]), .o_rot_r2c2(entries[8]),
        .o_axis_zero(o_axis_zero)
    );

    rotation_checker #(.FRAC_BITS(FRAC_BITS)) rot_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .i_in_ready(o_ready),
        .i_sine(sine), .i_cosine(cosine), .i_ax(ax), .i_ay(ay), .i_az(az),
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_entries(entries), .i_axis_zero(o_axis_zero),
        .o_mismatches(mismatches), .o_pending(pending),
        .o_matrices(matrices), .o_zero_axes(zero_axes)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: stall style changes every so often, including no stalls at all
    always @(negedge i_clk) begin
        int mode;
        int left;
        if (!i_rst_n) begin
            i_ready = 1'b0;
            mode = 0;
            left = 0;
        end else begin
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(10, 200);
            end
            left--;
            case (mode)
                0: i_ready = 1'b1;
                1: i_ready = ($urandom_range(0, 9) < 7);
                2: i_ready = (left % 8) < 5;
                default: i_ready = ($urandom_range(0, 9) < 2);
            endcase
        end
    end

    // one transfer; holds valid and payload until accepted
    task automatic send_item(input logic [15:0] s, c, x, y, z);
        @(negedge i_clk);
        i_valid = 1'b1;
        sine = s;
        cosine = c;
        ax = x;
        ay = y;
        az = z;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
    endtask

    // axis component with a random magnitude range so small axes show up often
    function automatic logic [15:0] rand_axis();
        logic signed [15:0] v;
        v = 16'($urandom_range(0, 65535));
        case ($urandom_range(0, 9))
            0: v = 0;
            1, 2: v = v >>> $urandom_range(8, 15);
            3, 4: v = v >>> $urandom_range(1, 7);
            default: ;
        endcase
        return v;
    endfunction

    initial begin
        int burst;
        logic [15:0] s, c;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // zero axis, identity angle, unit axes, extreme fields, odd angles
        send_item(16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h0000);
        send_item(16'h7fff, 16'h8000, 16'h0000, 16'h0000, 16'h0000);
        send_item(16'h0000, 16'h4000, 16'h0001, 16'h0000, 16'h0000);
        send_item(16'h4000, 16'h0000, 16'h0000, 16'h0001, 16'h0000);
        send_item(16'hc000, 16'h0000, 16'h0000, 16'h0000, 16'h7fff);
        send_item(16'h2d41, 16'h2d41, 16'h8000, 16'h8000, 16'h8000);
        send_item(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_item(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h0001);
        send_item(16'h8000, 16'h7fff, 16'hffff, 16'hffff, 16'hffff);
        send_item(16'h7fff, 16'h8000, 16'h0001, 16'h0001, 16'h0001);
        send_item(16'h0000, 16'hc000, 16'h8000, 16'h0000, 16'h0000);
        send_item(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h1234);
        send_item(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'hedcb);
        send_item(16'h376d, 16'h2000, 16'h0003, 16'h0004, 16'h0000);
        send_item(16'hffff, 16'h0001, 16'h0000, 16'hfffd, 16'h0004);
        send_item(16'h0000, 16'h0000, 16'h7fff, 16'h0000, 16'h8000);

        // let the pipeline drain completely before the random part
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending != 0) @(posedge i_clk);

        burst = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (burst == 0) begin
                idle_cycles($urandom_range(0, 6));
                burst = $urandom_range(1, 40);
            end
            burst--;
            if ($urandom_range(0, 3) != 0) begin
                // plausible angle: cosine in range, sine of similar size
                c = 16'($urandom_range(0, 32768) - 16384);
                s = 16'($urandom_range(0, 32768) - 16384);
            end else begin
                c = 16'($urandom_range(0, 65535));
                s = 16'($urandom_range(0, 65535));
            end
            send_item(s, c, rand_axis(), rand_axis(), rand_axis());
        end
        @(negedge i_clk);
        i_valid = 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("Checked %0d rotation matrices (%0d with a zero axis), directed and random,",
                 matrices, zero_axes);
        $display("with bursty input and a stalling receiver.");
        if (mismatches == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
